### hw/rtl/idqs_pkg.sv
// shared types and constants for the indexed deque with sort
// command and status codes, input and result word layouts; no dependencies
`timescale 1ns / 1ps

package idqs_pkg;

  // default number of list entries
  localparam int DEF_CAPACITY = 64;

  // data width of one list entry
  localparam int DATA_W = 32;

  // width of the position and element count fields
  localparam int POS_W = 7;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_REMOVE_AT  = 3'd5,
    CMD_CLEAR      = 3'd6,
    CMD_SORT       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [POS_W-1:0]         element_count;
    status_t                  status;
  } out_word_t;

endpackage

### hw/rtl/indexed_deque_with_sort.sv
// indexed deque with sort. clear, errors and sort of under two entries go straight
// to the result word; push back or insert at the end writes the new word directly;
// other pushes and inserts first shift the entries from the position up; pops and
// remove shift them down; sort scans and swaps, the store walked one entry a cycle.
// one command at a time; the next word can be taken in the cycle after the last
// result is registered, even while it waits. reset clears count and sequencer, not entries.
`timescale 1ns / 1ps

module indexed_deque_with_sort #(
  parameter int CAPACITY = idqs_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  idqs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output idqs_pkg::out_word_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                        res_valid;
  logic                        res_ready;
  idqs_pkg::out_word_t         res_word;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [idqs_pkg::DATA_W-1:0] wr_data;
  logic [AW-1:0]               rd_addr;
  logic [idqs_pkg::DATA_W-1:0] rd_data;
  logic                        out_valid_r;
  idqs_pkg::out_word_t         out_data_r;

  // sequencer
  idqs_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_valid),
    .cmd_ready (in_ready),
    .cmd_word  (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // entry store
  idqs_ram #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result word register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/idqs_ram.sv
// entry store: one write port, one read port, registered read data
// depends on idqs_pkg for the data width
`timescale 1ns / 1ps

module idqs_ram #(
  parameter int CAPACITY = idqs_pkg::DEF_CAPACITY,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [idqs_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [idqs_pkg::DATA_W-1:0] rd_data
);

  logic [idqs_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [idqs_pkg::DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/idqs_ctrl.sv
// command sequencer: decodes a word, walks the entry store to shift or sort,
// keeps the element count; depends on idqs_pkg and drives idqs_ram ports
`timescale 1ns / 1ps

module idqs_ctrl #(
  parameter int CAPACITY = idqs_pkg::DEF_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  idqs_pkg::in_word_t          cmd_word,
  output logic                        res_valid,
  input  logic                        res_ready,
  output idqs_pkg::out_word_t         res_word,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [idqs_pkg::DATA_W-1:0] wr_data,
  output logic [AW-1:0]               rd_addr,
  input  logic [idqs_pkg::DATA_W-1:0] rd_data
);

  localparam int CMPW = (CW > idqs_pkg::POS_W) ? CW : idqs_pkg::POS_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INS    = 8'b0000_0010,
    S_INS_WR = 8'b0000_0100,
    S_REM    = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_SWAP_A = 8'b0010_0000,
    S_SWAP_B = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               ptr_r, ptr_nxt;
  logic [CW-1:0]               left_r, left_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               paddr_r, paddr_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic [idqs_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [AW-1:0]               i_r, i_nxt;
  logic [idqs_pkg::DATA_W-1:0] min_r, min_nxt;
  logic [AW-1:0]               midx_r, midx_nxt;
  logic [idqs_pkg::DATA_W-1:0] oldi_r, oldi_nxt;
  logic [idqs_pkg::DATA_W-1:0] popped_r, popped_nxt;
  idqs_pkg::status_t           status_r, status_nxt;

  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] tpos;
  logic [CW-1:0]   i_ext;
  logic            full;
  logic            empty;
  logic            issue;
  logic            drained;

  assign cnt_x   = CMPW'(count_r);
  assign pos_x   = CMPW'(cmd_word.position);
  assign i_ext   = CW'(i_r);
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign issue   = (left_r != '0);
  assign drained = (left_r == '0) && !pend_r;

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FINISH);
  assign rd_addr   = ptr_r;

  assign res_word.popped_value  = $signed(popped_r);
  assign res_word.element_count = cnt_x[idqs_pkg::POS_W-1:0];
  assign res_word.status        = status_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    left_nxt   = left_r;
    pend_nxt   = 1'b0;
    paddr_nxt  = paddr_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    i_nxt      = i_r;
    min_nxt    = min_r;
    midx_nxt   = midx_r;
    oldi_nxt   = oldi_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    tpos       = '0;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = val_r;

    // read stream shared by the walking states
    if ((state_r == S_INS) || (state_r == S_REM) || (state_r == S_SCAN)) begin
      if (issue) begin
        pend_nxt  = 1'b1;
        paddr_nxt = ptr_r;
        left_nxt  = left_r - 1'b1;
        ptr_nxt   = (state_r == S_INS) ? ptr_r - 1'b1 : ptr_r + 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          popped_nxt = '0;
          status_nxt = idqs_pkg::ST_OK;
          val_nxt    = cmd_word.value;
          state_nxt  = S_FINISH;
          unique case (cmd_word.cmd)
            idqs_pkg::CMD_PUSH_FRONT, idqs_pkg::CMD_PUSH_BACK,
            idqs_pkg::CMD_INSERT_AT: begin
              priority case (cmd_word.cmd)
                idqs_pkg::CMD_PUSH_FRONT: tpos = '0;
                idqs_pkg::CMD_PUSH_BACK:  tpos = cnt_x;
                default:                  tpos = pos_x;
              endcase
              if (full) begin
                status_nxt = idqs_pkg::ST_FULL;
              end else if (tpos > cnt_x) begin
                status_nxt = idqs_pkg::ST_RANGE;
              end else begin
                count_nxt = count_r + 1'b1;
                pos_nxt   = tpos[AW-1:0];
                ptr_nxt   = AW'(count_r - 1'b1);
                left_nxt  = CW'(cnt_x - tpos);
                state_nxt = (cnt_x == tpos) ? S_INS_WR : S_INS;
              end
            end
            idqs_pkg::CMD_POP_FRONT, idqs_pkg::CMD_POP_BACK,
            idqs_pkg::CMD_REMOVE_AT: begin
              priority case (cmd_word.cmd)
                idqs_pkg::CMD_POP_FRONT: tpos = '0;
                idqs_pkg::CMD_POP_BACK:  tpos = cnt_x - 1'b1;
                default:                 tpos = pos_x;
              endcase
              if (empty) begin
                status_nxt = idqs_pkg::ST_EMPTY;
              end else if (tpos >= cnt_x) begin
                status_nxt = idqs_pkg::ST_RANGE;
              end else begin
                count_nxt = count_r - 1'b1;
                pos_nxt   = tpos[AW-1:0];
                ptr_nxt   = tpos[AW-1:0];
                left_nxt  = CW'(cnt_x - tpos);
                state_nxt = S_REM;
              end
            end
            idqs_pkg::CMD_CLEAR: begin
              if (empty) begin
                status_nxt = idqs_pkg::ST_EMPTY;
              end else begin
                count_nxt = '0;
              end
            end
            idqs_pkg::CMD_SORT: begin
              if (count_r > CW'(1)) begin
                i_nxt     = '0;
                ptr_nxt   = '0;
                left_nxt  = count_r;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      // shift entries up by one, top first
      S_INS: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = paddr_r + 1'b1;
          wr_data = rd_data;
        end
        if (drained) begin
          state_nxt = S_INS_WR;
        end
      end

      // drop the new word into the gap
      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = val_r;
        state_nxt = S_FINISH;
      end

      // take out the entry at the position, close the gap by shifting the entries above it down
      S_REM: begin
        if (pend_r) begin
          if (paddr_r == pos_r) begin
            popped_nxt = rd_data;
          end else begin
            wr_en   = 1'b1;
            wr_addr = paddr_r - 1'b1;
            wr_data = rd_data;
          end
        end
        if (drained) begin
          state_nxt = S_FINISH;
        end
      end

      // find the smallest entry from i to the end, first one wins on ties
      S_SCAN: begin
        if (pend_r) begin
          if (paddr_r == i_r) begin
            min_nxt  = rd_data;
            midx_nxt = paddr_r;
            oldi_nxt = rd_data;
          end else if ($signed(rd_data) < $signed(min_r)) begin
            min_nxt  = rd_data;
            midx_nxt = paddr_r;
          end
        end
        if (drained) begin
          state_nxt = S_SWAP_A;
        end
      end

      // old entry i goes to where the minimum was
      S_SWAP_A: begin
        wr_en     = 1'b1;
        wr_addr   = midx_r;
        wr_data   = oldi_r;
        state_nxt = S_SWAP_B;
      end

      // minimum goes to entry i, then the next pass while one is left, else the result
      S_SWAP_B: begin
        wr_en   = 1'b1;
        wr_addr = i_r;
        wr_data = min_r;
        i_nxt   = i_r + 1'b1;
        if ((i_ext + CW'(2)) < count_r) begin
          ptr_nxt   = i_r + 1'b1;
          left_nxt  = count_r - i_ext - 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end

      // hand the result word on
      S_FINISH: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      left_r  <= left_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    paddr_r  <= paddr_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    i_r      <= i_nxt;
    min_r    <= min_nxt;
    midx_r   <= midx_nxt;
    oldi_r   <= oldi_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

endmodule

### tb/deque_result_checker.sv
// result checker for the indexed deque with sort: keeps a shadow list, predicts
// each result word and compares it with what the block returns; uses idqs_pkg
`timescale 1ns / 1ps

module deque_result_checker
  import idqs_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_word_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_word_t        out_data,
  output int               fail_count,
  output int               results_due,
  output logic [POS_W-1:0] list_len
);

  // shadow copy of the list, entry 0 at the front
  logic signed [DATA_W-1:0] shadow [CAPACITY];
  int                       shadow_len;

  // result words still owed by the block, oldest first
  out_word_t                due_q [$];

  initial begin
    fail_count  = 0;
    results_due = 0;
    list_len    = '0;
    shadow_len  = 0;
  end

  // apply one command to the shadow list and return the word it should give
  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t                r;
    logic signed [DATA_W-1:0] t;
    int                       p;
    int                       m;
    r.popped_value = '0;
    r.status       = ST_OK;
    p              = int'(w.position);
    case (w.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (w.cmd == CMD_PUSH_FRONT) p = 0;
          else if (w.cmd == CMD_PUSH_BACK) p = shadow_len;
          if (p > shadow_len) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = shadow_len; i > p; i--) shadow[i] = shadow[i-1];
            shadow[p] = w.value;
            shadow_len++;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
        // empty wins over a bad position
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (w.cmd == CMD_POP_FRONT) p = 0;
          else if (w.cmd == CMD_POP_BACK) p = shadow_len - 1;
          if (p >= shadow_len) begin
            r.status = ST_RANGE;
          end else begin
            r.popped_value = shadow[p];
            for (int i = p; i + 1 < shadow_len; i++) shadow[i] = shadow[i+1];
            shadow_len--;
          end
        end
      end
      CMD_CLEAR: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else shadow_len = 0;
      end
      CMD_SORT: begin
        // ascending by signed value
        for (int i = 0; i + 1 < shadow_len; i++) begin
          m = i;
          for (int j = i + 1; j < shadow_len; j++)
            if (shadow[j] < shadow[m]) m = j;
          t         = shadow[i];
          shadow[i] = shadow[m];
          shadow[m] = t;
        end
      end
    endcase
    r.element_count = POS_W'(shadow_len);
    return r;
  endfunction

  // watch both channels; the returned word is checked before the new command
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      shadow_len = 0;
      due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with none expected: popped %0d count %0d status %0d",
                     $realtime, out_data.popped_value, out_data.element_count,
                     out_data.status);
        end else begin
          want = due_q.pop_front();
          if (out_data.popped_value !== want.popped_value ||
              out_data.element_count !== want.element_count ||
              out_data.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected/actual popped %0d/%0d count %0d/%0d status %0d/%0d",
                       $realtime, want.popped_value, out_data.popped_value,
                       want.element_count, out_data.element_count,
                       want.status, out_data.status);
          end
        end
      end
      if (in_valid && in_ready) due_q.push_back(apply_command(in_data));
    end
    results_due = due_q.size();
    list_len    = POS_W'(shadow_len);
  end

endmodule

### tb/indexed_deque_with_sort_tb.sv
// top of the indexed deque with sort testbench: clock, reset, stimulus and verdict
// depends on idqs_pkg, indexed_deque_with_sort and deque_result_checker
`timescale 1ns / 1ps

module indexed_deque_with_sort_tb;
  import idqs_pkg::*;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int RANDOM_WORDS = 1900;
  localparam int STALL_LIMIT  = 20000;
  localparam int LONG_HOLD    = 500;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_word_t        out_data;

  int               fail_count;
  int               results_due;
  logic [POS_W-1:0] list_len;

  int               send_idle_pct  = 0;
  int               recv_idle_pct  = 0;
  bit               long_hold_go   = 1'b0;
  bit               long_hold_done = 1'b0;
  int               quiet_cycles   = 0;

  indexed_deque_with_sort #(.CAPACITY(CAPACITY)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  deque_result_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .results_due (results_due),
    .list_len    (list_len)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_go && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_word_t word_of(input cmd_t c, input int p,
                                       input logic [DATA_W-1:0] v);
    in_word_t w;
    w.cmd      = c;
    w.position = POS_W'(p);
    w.value    = v;
    return w;
  endfunction

  // random command shaped by the traffic mode and the current list length
  function automatic in_word_t next_word(input traffic_mode_t mode);
    in_word_t w;
    int       grow_pct;
    int       r;
    int       len;
    len      = int'(list_len);
    grow_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 20 : 55;
    r        = $urandom_range(99);
    if (r < 3) begin
      w.cmd = CMD_SORT;
    end else if (r < 4) begin
      w.cmd = CMD_CLEAR;
    end else if (r < grow_pct) begin
      case ($urandom_range(2))
        0:       w.cmd = CMD_PUSH_FRONT;
        1:       w.cmd = CMD_PUSH_BACK;
        default: w.cmd = CMD_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       w.cmd = CMD_POP_FRONT;
        1:       w.cmd = CMD_POP_BACK;
        default: w.cmd = CMD_REMOVE_AT;
      endcase
    end
    // mostly legal positions, some anywhere in the field
    if ($urandom_range(9) == 0)
      w.position = POS_W'($urandom);
    else if (w.cmd == CMD_REMOVE_AT && len > 0)
      w.position = POS_W'($urandom_range(len - 1));
    else
      w.position = POS_W'($urandom_range(len));
    // extremes, small values for duplicates, otherwise anything
    r = $urandom_range(19);
    if (r == 0)     w.value = 32'h7FFF_FFFF;
    else if (r == 1) w.value = 32'h8000_0000;
    else if (r < 6)  w.value = DATA_W'($urandom_range(8)) - DATA_W'(4);
    else             w.value = $urandom;
    return w;
  endfunction

  // present one word from a falling edge and hold it until taken
  task automatic offer_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // stimulus and verdict
  initial begin
    in_word_t      plan [$];
    in_word_t      w;
    cmd_t          c;
    traffic_mode_t mode;
    int            seg_left;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    mode     = MODE_FILL;
    seg_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 32;
    recv_idle_pct = 71;

    // directed: errors on an empty list, both extremes, ends and middle
    plan.push_back(word_of(CMD_POP_FRONT, 0, 0));
    plan.push_back(word_of(CMD_POP_BACK, 0, 0));
    plan.push_back(word_of(CMD_REMOVE_AT, 0, 0));
    plan.push_back(word_of(CMD_REMOVE_AT, 127, 0));
    plan.push_back(word_of(CMD_CLEAR, 0, 0));
    plan.push_back(word_of(CMD_SORT, 0, 0));
    plan.push_back(word_of(CMD_INSERT_AT, 1, 7));
    plan.push_back(word_of(CMD_INSERT_AT, 0, 5));
    plan.push_back(word_of(CMD_SORT, 0, 0));
    plan.push_back(word_of(CMD_PUSH_FRONT, 0, 32'h7FFF_FFFF));
    plan.push_back(word_of(CMD_PUSH_BACK, 0, 32'h8000_0000));
    plan.push_back(word_of(CMD_INSERT_AT, 3, 32'hFFFF_FFFF));
    plan.push_back(word_of(CMD_INSERT_AT, 5, 9));
    plan.push_back(word_of(CMD_PUSH_BACK, 0, 5));
    plan.push_back(word_of(CMD_REMOVE_AT, 5, 0));
    plan.push_back(word_of(CMD_REMOVE_AT, 127, 0));
    plan.push_back(word_of(CMD_SORT, 0, 0));
    plan.push_back(word_of(CMD_REMOVE_AT, 2, 0));
    plan.push_back(word_of(CMD_POP_FRONT, 0, 0));
    plan.push_back(word_of(CMD_POP_BACK, 0, 0));
    plan.push_back(word_of(CMD_CLEAR, 0, 0));

    // fill past capacity, sort a full list, then the edges of a full list
    for (int i = 0; i < CAPACITY + 6; i++) begin
      case ($urandom_range(2))
        0:       c = CMD_PUSH_FRONT;
        1:       c = CMD_PUSH_BACK;
        default: c = CMD_INSERT_AT;
      endcase
      plan.push_back(word_of(c, $urandom_range(i < CAPACITY ? i : CAPACITY), $urandom));
    end
    plan.push_back(word_of(CMD_SORT, 0, 0));
    plan.push_back(word_of(CMD_REMOVE_AT, CAPACITY, 0));
    plan.push_back(word_of(CMD_INSERT_AT, 0, 1));
    plan.push_back(word_of(CMD_POP_BACK, 0, 0));
    plan.push_back(word_of(CMD_INSERT_AT, CAPACITY, 1));
    plan.push_back(word_of(CMD_INSERT_AT, CAPACITY - 1, 1));
    plan.push_back(word_of(CMD_CLEAR, 0, 0));

    foreach (plan[i]) begin
      @(negedge clk);
      offer_word(plan[i]);
    end

    // random traffic in segments of fill, drain and mixed use
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == 600) begin
        send_idle_pct = 71;
        recv_idle_pct = 32;
      end else if (k == 1250) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_go  = 1'b1;
      end
      if (seg_left == 0) begin
        mode     = traffic_mode_t'($urandom_range(2));
        seg_left = $urandom_range(120, 20);
      end
      seg_left--;
      @(negedge clk);
      w = next_word(mode);
      offer_word(w);
    end

    // let the last results drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
